>>> sv/dbp_pkg.sv
// ----------------------------------------------------------------------------
// dbp_pkg
// Shared widths, constants and the cell bundle for the distance and bearing
// block.
// ----------------------------------------------------------------------------
package dbp_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 20;

  localparam int unsigned POS_W       = 32;
  localparam int unsigned HEAD_W      = 17;
  localparam int unsigned DIST_W      = 33;
  localparam int unsigned BEAR_W      = 17;
  localparam int unsigned DIFF_W      = 33;
  localparam int unsigned ABS_W       = 32;
  localparam int unsigned SQ_W        = 64;
  localparam int unsigned RAD_W       = 66;
  localparam int unsigned REM_W       = 35;
  localparam int unsigned ROOT_W      = 33;
  localparam int unsigned VEC_W       = 64;
  localparam int unsigned ANG_W       = 32;
  localparam int unsigned ANG_OUT_W   = 20;
  localparam int unsigned BEAR_EXT_W  = 21;
  localparam int unsigned GUARD_BITS  = 28;
  localparam int unsigned ROUND_SHIFT = 13;
  localparam int unsigned ATAN_N      = 32;
  localparam int unsigned NUM_CELLS   = 33;

  localparam logic signed [ANG_W-1:0]      DEG180     = 32'sd188743680;
  localparam logic signed [ANG_W-1:0]      ROUND_HALF = 32'sd4096;
  localparam logic signed [BEAR_EXT_W-1:0] FULL_TURN  = 21'sd46080;

  // atan(2^-i) in units of 2^-20 degree
  localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_N] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
    32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
    32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
    32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
    32'sd917,      32'sd458,      32'sd229,      32'sd115,
    32'sd57,       32'sd29,       32'sd14,       32'sd7,
    32'sd4,        32'sd2,        32'sd1,        32'sd0,
    32'sd0,        32'sd0,        32'sd0,        32'sd0
  };

  typedef struct packed {
    logic signed [VEC_W-1:0]  x;
    logic signed [VEC_W-1:0]  y;
    logic signed [ANG_W-1:0]  z;
    logic                     zero;
    logic signed [HEAD_W-1:0] heading;
    logic [RAD_W-1:0]         rad;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
  } cell_data_t;

endpackage

>>> sv/dbp_in_if.sv
// ----------------------------------------------------------------------------
// dbp_in_if
// Input channel: target point and robot pose, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dbp_in_if;
  import dbp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  target_x;
  logic signed [POS_W-1:0]  target_y;
  logic signed [POS_W-1:0]  robot_x;
  logic signed [POS_W-1:0]  robot_y;
  logic signed [HEAD_W-1:0] robot_heading;

  modport source (
    output valid, target_x, target_y, robot_x, robot_y, robot_heading,
    input  ready
  );

  modport sink (
    input  valid, target_x, target_y, robot_x, robot_y, robot_heading,
    output ready
  );

endinterface

>>> sv/dbp_out_if.sv
// ----------------------------------------------------------------------------
// dbp_out_if
// Output channel: distance and bearing, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dbp_out_if;
  import dbp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [DIST_W-1:0]        distance;
  logic signed [BEAR_W-1:0] bearing;

  modport source (
    output valid, distance, bearing,
    input  ready
  );

  modport sink (
    input  valid, distance, bearing,
    output ready
  );

endinterface

>>> sv/dbp_prep.sv
// ----------------------------------------------------------------------------
// dbp_prep
// Front pipeline: position differences, squares, radicand and the CORDIC
// pre-rotation into the right half plane.
// ----------------------------------------------------------------------------
module dbp_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  dbp_in_if.sink             in_i,
  output logic               valid_o,
  output dbp_pkg::cell_data_t data_o,
  input  logic               ready_i
);
  import dbp_pkg::*;

  logic                     v1_q, v2_q, v3_q;
  logic                     r1, r2, r3;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic signed [HEAD_W-1:0] head1_q, head2_q;
  logic [SQ_W-1:0]          sqa_q, sqb_q;
  logic signed [VEC_W-1:0]  x_q, y_q;
  logic signed [ANG_W-1:0]  z_q;
  logic                     zero_q;
  cell_data_t               data_q;

  logic signed [DIFF_W-1:0] dx_d, dy_d;
  logic [ABS_W-1:0]         ax, ay;
  logic signed [VEC_W-1:0]  x0, y0, x_d, y_d;
  logic signed [ANG_W-1:0]  z_d;
  logic [RAD_W-1:0]         rad_d;

  assign r3 = !v3_q || ready_i;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_i.ready = r1;
  assign valid_o = v3_q;
  assign data_o  = data_q;

  always_comb begin
    dx_d = DIFF_W'(in_i.target_x) - DIFF_W'(in_i.robot_x);
    dy_d = DIFF_W'(in_i.target_y) - DIFF_W'(in_i.robot_y);
  end

  always_comb begin
    ax = dx_q[DIFF_W-1] ? ABS_W'(-dx_q) : dx_q[ABS_W-1:0];
    ay = dy_q[DIFF_W-1] ? ABS_W'(-dy_q) : dy_q[ABS_W-1:0];
    x0 = VEC_W'(dx_q) <<< GUARD_BITS;
    y0 = VEC_W'(dy_q) <<< GUARD_BITS;
    if (dx_q[DIFF_W-1]) begin
      x_d = -x0;
      y_d = -y0;
      z_d = dy_q[DIFF_W-1] ? -DEG180 : DEG180;
    end else begin
      x_d = x0;
      y_d = y0;
      z_d = '0;
    end
  end

  assign rad_d = RAD_W'({1'b0, sqa_q} + {1'b0, sqb_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_i.valid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_i.valid) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      head1_q <= in_i.robot_heading;
    end
    if (r2 && v1_q) begin
      sqa_q   <= SQ_W'(ax) * SQ_W'(ax);
      sqb_q   <= SQ_W'(ay) * SQ_W'(ay);
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      zero_q  <= (dx_q == '0) && (dy_q == '0);
      head2_q <= head1_q;
    end
    if (r3 && v2_q) begin
      data_q.x       <= x_q;
      data_q.y       <= y_q;
      data_q.z       <= z_q;
      data_q.zero    <= zero_q;
      data_q.heading <= head2_q;
      data_q.rad     <= rad_d;
      data_q.rem     <= '0;
      data_q.root    <= '0;
    end
  end

endmodule

>>> sv/dbp_cell.sv
// ----------------------------------------------------------------------------
// dbp_cell
// One cell of the chain: one square root digit and, in the first cells,
// one CORDIC vectoring iteration.
// ----------------------------------------------------------------------------
module dbp_cell #(
  parameter int unsigned CELL_IDX     = 0,
  parameter int unsigned CORDIC_STEPS = dbp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  dbp_pkg::cell_data_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  output dbp_pkg::cell_data_t data_o,
  input  logic                ready_i
);
  import dbp_pkg::*;

  logic                    valid_q;
  cell_data_t              data_q;
  cell_data_t              data_d;
  logic [REM_W+1:0]        rem_sh;
  logic [REM_W+1:0]        trial;
  logic signed [VEC_W-1:0] x_n, y_n;
  logic signed [ANG_W-1:0] z_n;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    rem_sh = {data_i.rem, data_i.rad[RAD_W-1 -: 2]};
    trial  = (REM_W+2)'({data_i.root, 2'b01});
  end

  if (CELL_IDX < CORDIC_STEPS) begin : g_rot
    logic signed [VEC_W-1:0] xs, ys;
    always_comb begin
      xs = data_i.x >>> CELL_IDX;
      ys = data_i.y >>> CELL_IDX;
      if (!data_i.y[VEC_W-1]) begin
        x_n = data_i.x + ys;
        y_n = data_i.y - xs;
        z_n = data_i.z + ATAN_TAB[CELL_IDX];
      end else begin
        x_n = data_i.x - ys;
        y_n = data_i.y + xs;
        z_n = data_i.z - ATAN_TAB[CELL_IDX];
      end
    end
  end else begin : g_pass
    always_comb begin
      x_n = data_i.x;
      y_n = data_i.y;
      z_n = data_i.z;
    end
  end

  always_comb begin
    data_d         = data_i;
    data_d.x       = x_n;
    data_d.y       = y_n;
    data_d.z       = z_n;
    data_d.rad     = data_i.rad << 2;
    if (rem_sh >= trial) begin
      data_d.rem  = REM_W'(rem_sh - trial);
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_sh[REM_W-1:0];
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> sv/dbp_finish.sv
// ----------------------------------------------------------------------------
// dbp_finish
// Tail pipeline: round the root and the angle, subtract the heading, fold
// the bearing and hold the result for the receiver.
// ----------------------------------------------------------------------------
module dbp_finish (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  dbp_pkg::cell_data_t data_i,
  output logic                ready_o,
  dbp_out_if.source           out_o
);
  import dbp_pkg::*;

  logic                         va_q, vb_q;
  logic                         rb;
  logic [DIST_W-1:0]            dist_a_q, dist_b_q;
  logic signed [ANG_OUT_W-1:0]  ang_q;
  logic signed [HEAD_W-1:0]     head_q;
  logic signed [BEAR_W-1:0]     bear_q;

  logic                         rnd;
  logic signed [ANG_W:0]        zsum;
  logic signed [ANG_OUT_W-1:0]  ang_d;
  logic signed [BEAR_EXT_W-1:0] bext, bfold;

  assign rb      = !vb_q || out_o.ready;
  assign ready_o = !va_q || rb;

  assign out_o.valid    = vb_q;
  assign out_o.distance = dist_b_q;
  assign out_o.bearing  = bear_q;

  always_comb begin
    rnd   = data_i.rem > REM_W'(data_i.root);
    zsum  = (ANG_W+1)'(data_i.z) + (ANG_W+1)'(ROUND_HALF);
    ang_d = data_i.zero ? '0 : ANG_OUT_W'(zsum >>> ROUND_SHIFT);
  end

  always_comb begin
    bext = BEAR_EXT_W'(ang_q) - BEAR_EXT_W'(head_q);
    if (bext <= -FULL_TURN) begin
      bfold = bext + FULL_TURN;
    end else if (bext >= FULL_TURN) begin
      bfold = bext - FULL_TURN;
    end else begin
      bfold = bext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_o) va_q <= valid_i;
      if (rb) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dist_a_q <= data_i.root + DIST_W'(rnd);
      ang_q    <= ang_d;
      head_q   <= data_i.heading;
    end
    if (rb && va_q) begin
      dist_b_q <= dist_a_q;
      bear_q   <= bfold[BEAR_W-1:0];
    end
  end

endmodule

>>> sv/distance_and_bearing_to_point.sv
// ----------------------------------------------------------------------------
// distance_and_bearing_to_point
// Distance and bearing from a robot pose to a target point.
//
// Input channel in_i carries the target point and robot position (signed
// Q16.16) and the heading (1/128 degree). Output channel out_o returns the
// rounded Euclidean distance (unsigned Q17.16) and the bearing, atan2 of the
// position difference minus the heading, folded once toward zero at +-360 degrees.
// Both channels move an item when valid and ready are high at a clock edge.
// Each item passes 3 front stages, a chain of 33 cells (one square root
// digit each, the first CORDIC_STEPS cells also run one CORDIC iteration),
// and 2 tail stages; one item is taken per cycle unless the pipeline stalls.
// Every stage has its own valid bit and stalls only when full and its
// successor is stalled, so input is still taken while a result waits, until
// the pipeline fills. Reset clears all valid bits; no item is held across it.
// ----------------------------------------------------------------------------
module distance_and_bearing_to_point #(
  parameter int unsigned CORDIC_STEPS = dbp_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dbp_in_if.sink     in_i,
  dbp_out_if.source  out_o
);
  import dbp_pkg::*;

  logic       valid_w [NUM_CELLS+1];
  logic       ready_w [NUM_CELLS+1];
  cell_data_t data_w  [NUM_CELLS+1];

  dbp_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (valid_w[0]),
    .data_o  (data_w[0]),
    .ready_i (ready_w[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    dbp_cell #(
      .CELL_IDX     (k),
      .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[k]),
      .data_i  (data_w[k]),
      .ready_o (ready_w[k]),
      .valid_o (valid_w[k+1]),
      .data_o  (data_w[k+1]),
      .ready_i (ready_w[k+1])
    );
  end

  dbp_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_w[NUM_CELLS]),
    .data_i  (data_w[NUM_CELLS]),
    .ready_o (ready_w[NUM_CELLS]),
    .out_o   (out_o)
  );

endmodule
